FILE: design/stsrm_pkg.sv
`default_nettype none

package stsrm_pkg;

  // Item opcodes carried in the slave-side tuser.
  typedef enum logic [1:0] {
    OP_LOAD_X  = 2'd0,
    OP_LOWER   = 2'd1,
    OP_UPPER   = 2'd2,
    OP_END_ROW = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ALPHA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_BASE  = 2'd2;

  // What an item does once it has left the accept stage.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ACC  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  localparam logic signed [65:0] Y_MAX = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] Y_MIN = {34'h3_FFFF_FFFF, 32'h8000_0000};

  // Partial products of a closed row, handed to the finishing stages.
  typedef struct packed {
    logic               valid;
    logic signed [63:0] ath;
    logic signed [48:0] atl;
    logic signed [63:0] bterm;
    logic               sum_clamped;
    logic [15:0]        row;
  } fin_req_t;

  // Finished row result.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] y;
    logic [15:0]        row;
    logic               saturated;
  } result_t;

endpackage

`default_nettype wire

FILE: design/split_triangular_sparse_row_mac.sv
// A transaction that closes a row passes stage 1, the product stage, the accumulate
// stage and stage 4 before its result is registered for m_axis_tvalid.
// Throughput: one input transaction per cycle unless a stall holds the pipeline, limited
// by the single x memory read port and the one multiplier in the product stage.
// Reset: synchronous and active high; control state, gains and the row state
// return to their initial values. The x memory is not cleared and must be loaded.
`default_nettype none

module split_triangular_sparse_row_mac
  import stsrm_pkg::*;
#(
  parameter int X_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // index[10:0], value[42:11], old_y[74:43], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // y_value[31:0], row_number[47:32]
  output logic [0:0]       m_axis_tuser,  // saturated[0]
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
  localparam logic [16:0] DEPTH17 = 17'(X_DEPTH);

  // Configuration registers. Users must write only while idle; the block does not enforce it.
  logic signed [31:0] alpha_gain;
  logic signed [31:0] beta_gain;
  logic               index_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_gain <= 32'sd65536;
      beta_gain  <= 32'sd0;
      index_base <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA: alpha_gain <= cfg_data;
        CFG_BETA:  beta_gain  <= cfg_data;
        CFG_BASE:  index_base <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpacked input fields.
  opcode_t            in_op;
  logic [10:0]        in_index;
  logic signed [31:0] in_value;
  logic signed [31:0] in_old_y;

  assign in_op    = opcode_t'(s_axis_tuser);
  assign in_index = s_axis_tdata[10:0];
  assign in_value = s_axis_tdata[42:11];
  assign in_old_y = s_axis_tdata[74:43];

  // The whole pipeline moves together, and it halts only when a finished row
  // is waiting at the last stage while the output register still holds one not being taken.
  result_t res;
  logic    out_valid;
  logic    en;
  logic    accept;

  assign en            = !(out_valid && !m_axis_tready && res.valid);
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  // Accept stage: column range check and the upper-diagonal skip.
  logic        diagonal_pending;
  logic [16:0] load_col;
  logic [16:0] col;
  logic        col_ok;
  logic        load_ok;
  logic        is_acc;
  kind_t       in_kind;

  always_comb begin
    load_col = {6'd0, in_index};
    col      = load_col - {16'd0, index_base};
    col_ok   = (in_index >= {10'd0, index_base}) && (col < DEPTH17);
    load_ok  = load_col < DEPTH17;
    case (in_op)
      OP_LOWER: is_acc = col_ok;
      OP_UPPER: is_acc = col_ok && !diagonal_pending;
      default:  is_acc = 1'b0;
    endcase
    if (is_acc) begin
      in_kind = KIND_ACC;
    end else if (in_op == OP_END_ROW) begin
      in_kind = KIND_END;
    end else begin
      in_kind = KIND_NONE;
    end
  end

  // The first upper entry of a row stands for the diagonal, which the lower
  // part already carries, so it is dropped whatever its column.
  always_ff @(posedge clk) begin
    if (rst) begin
      diagonal_pending <= 1'b1;
    end else if (accept) begin
      if (in_op == OP_UPPER) begin
        diagonal_pending <= 1'b0;
      end else if (in_op == OP_END_ROW) begin
        diagonal_pending <= 1'b1;
      end
    end
  end

  // x memory: one write port for loads, one registered read port for
  // nonzeros. Each item makes one access, so a load followed at once by a
  // read of the same entry sees the new value without any forwarding.
  logic [31:0] x_mem [X_DEPTH];
  logic [31:0] x_rd;

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_LOAD_X) && load_ok) begin
      x_mem[load_col[AW-1:0]] <= in_value;
    end
    if (accept && is_acc) begin
      x_rd <= x_mem[col[AW-1:0]];
    end
  end

  // Stage 1: item waiting for its x read.
  kind_t              s1_kind;
  logic signed [31:0] s1_value;
  logic signed [31:0] s1_old_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_kind <= KIND_NONE;
    end else if (en) begin
      s1_kind <= accept ? in_kind : KIND_NONE;
    end
    if (en) begin
      s1_value <= in_value;
      s1_old_y <= in_old_y;
    end
  end

  // Stage 2: the one multiplier. A nonzero forms value times x; a row end
  // uses it for the beta term, which is zero when beta is zero.
  kind_t              s2_kind;
  logic signed [63:0] s2_prod;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;

  always_comb begin
    if (s1_kind == KIND_END) begin
      mul_a = beta_gain;
      mul_b = s1_old_y;
    end else begin
      mul_a = s1_value;
      mul_b = x_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_kind <= KIND_NONE;
    end else if (en) begin
      s2_kind <= s1_kind;
    end
    if (en) begin
      s2_prod <= mul_a * mul_b;
    end
  end

  // Stage 3: saturating Q32.32 accumulation, or the close of the row with
  // the two alpha products taken from the high and low halves of the sum.
  logic signed [63:0] row_sum;
  logic               sum_clamped;
  logic [15:0]        row_counter;
  fin_req_t           fin_req;
  logic signed [64:0] acc_wide;
  logic               acc_ovf;
  logic signed [63:0] acc_sat;
  logic signed [31:0] sum_hi;
  logic signed [16:0] sum_lo;

  always_comb begin
    acc_wide = {row_sum[63], row_sum} + {s2_prod[63], s2_prod};
    acc_ovf  = acc_wide[64] != acc_wide[63];
    if (!acc_ovf) begin
      acc_sat = acc_wide[63:0];
    end else if (acc_wide[64]) begin
      acc_sat = SUM_MIN;
    end else begin
      acc_sat = SUM_MAX;
    end
    sum_hi = row_sum[63:32];
    sum_lo = {1'b0, row_sum[31:16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum       <= '0;
      sum_clamped   <= 1'b0;
      row_counter   <= '0;
      fin_req.valid <= 1'b0;
    end else if (en) begin
      fin_req.valid <= s2_kind == KIND_END;
      if (s2_kind == KIND_ACC) begin
        row_sum     <= acc_sat;
        sum_clamped <= sum_clamped || acc_ovf;
      end else if (s2_kind == KIND_END) begin
        row_sum     <= '0;
        sum_clamped <= 1'b0;
        row_counter <= row_counter + 16'd1;
      end
    end
    if (en) begin
      fin_req.ath         <= alpha_gain * sum_hi;
      fin_req.atl         <= 49'(alpha_gain) * 49'(sum_lo);
      fin_req.bterm       <= s2_prod;
      fin_req.sum_clamped <= sum_clamped;
      fin_req.row         <= row_counter;
    end
  end

  // Stage 4 and the combinational finish after it: combine, shift and clamp.
  stsrm_finish u_finish (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .req (fin_req),
    .res (res)
  );

  // Output register; a new result may load while the old one is taken.
  logic signed [31:0] out_y;
  logic [15:0]        out_row;
  logic               out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && res.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (en && res.valid) begin
      out_y   <= res.y;
      out_row <= res.row;
      out_sat <= res.saturated;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {out_row, out_y};
  assign m_axis_tuser[0] = out_sat;

  // Closing a row advances the row count by exactly one.
  a_row_count: assert property (@(posedge clk) disable iff (rst)
    (en && s2_kind == KIND_END) |=> row_counter == $past(row_counter) + 16'd1)
    else $error("row counter did not advance at row end");

  // A closed row leaves a clean sum for the next one.
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    (en && s2_kind == KIND_END) |=> (row_sum == '0 && !sum_clamped))
    else $error("row sum not cleared at row end");

  // After a row end the next upper entry is again taken as the diagonal.
  a_diag_rearm: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == OP_END_ROW) |=> diagonal_pending)
    else $error("diagonal skip not re-armed");

  // Input is held back only while a result sits unclaimed in the output and a new row waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && res.valid))
    else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

FILE: design/stsrm_finish.sv
`default_nettype none

module stsrm_finish
  import stsrm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire fin_req_t req,
  output result_t       res
);

  logic               s4_valid;
  logic signed [65:0] s4_sum;
  logic signed [63:0] s4_ath;
  logic               s4_flag;
  logic [15:0]        s4_row;

  logic signed [65:0] low;
  logic signed [65:0] r;

  // First half: the low partial product and the beta term meet here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= req.valid;
    end
    if (en) begin
      s4_sum  <= {{17{req.atl[48]}}, req.atl} + {{2{req.bterm[63]}}, req.bterm};
      s4_ath  <= req.ath;
      s4_flag <= req.sum_clamped;
      s4_row  <= req.row;
    end
  end

  // Second half: add the high product, then clamp to Q16.16.
  always_comb begin
    low = s4_sum >>> 16;
    r   = {{2{s4_ath[63]}}, s4_ath} + low;
    res.valid     = s4_valid;
    res.row       = s4_row;
    res.saturated = s4_flag;
    if (r > Y_MAX) begin
      res.y         = 32'sh7FFF_FFFF;
      res.saturated = 1'b1;
    end else if (r < Y_MIN) begin
      res.y         = 32'sh8000_0000;
      res.saturated = 1'b1;
    end else begin
      res.y = r[31:0];
    end
  end

endmodule

`default_nettype wire
